### rtl/gtrp_pkg.sv
// Types, codes and lane tables for the Green tensor rotate and project block.
// Used by green_tensor_rotate_project; no dependencies.
`default_nettype none

package gtrp_pkg;

    localparam int NUM_LANES  = 27;
    localparam int NUM_TERMS  = 17;
    localparam int NUM_ROWS   = 9;
    localparam int NUM_COMP   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Cosine register reset value: 1.0 in Q2.30
    localparam logic [31:0] COS_RESET = 32'h4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS = 3'd0,
        CFG_SIN = 3'd1,
        CFG_NX  = 3'd2,
        CFG_NY  = 3'd3,
        CFG_NZ  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_DISP = 1'b0,
        OP_TRAC = 1'b1
    } t_op;

    // Sample operand of a product lane
    typedef enum logic [3:0] {
        SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4,
        SRC_T5, SRC_T6, SRC_T7, SRC_T8, SRC_T9,
        SRC_D02, SRC_D67, SRC_ZERO
    } t_src;

    // Trig coefficient of a product lane
    typedef enum logic [3:0] {
        K_C, K_S, K_C2, K_S2, K_CS, K_C3, K_S3, K_CS2, K_C2S
    } t_coef;

    // Traction intermediate terms (yzx equals xyz)
    typedef enum logic [4:0] {
        TM_XXX, TM_XYY, TM_XZZ, TM_XXY, TM_XYZ, TM_XZX,
        TM_YXX, TM_YYY, TM_YZZ, TM_YXY, TM_YYZ,
        TM_ZXX, TM_ZYY, TM_ZZZ, TM_ZXY, TM_ZYZ, TM_ZZX
    } t_term;

    localparam t_src LANE_SRC_DISP [NUM_LANES] = '{
        SRC_T0, SRC_T2, SRC_D02, SRC_T1, SRC_T0, SRC_T2, SRC_T1, SRC_T3, SRC_T3,
        SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO,
        SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO,
        SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO
    };

    localparam t_coef LANE_COEF_DISP [NUM_LANES] = '{
        K_C2, K_S2, K_CS, K_C, K_S2, K_C2, K_S, K_C, K_S,
        K_C, K_C, K_C, K_C, K_C, K_C, K_C, K_C, K_C,
        K_C, K_C, K_C, K_C, K_C, K_C, K_C, K_C, K_C
    };

    localparam t_src LANE_SRC_TRAC [NUM_LANES] = '{
        SRC_T0, SRC_T1, SRC_T4, SRC_T0, SRC_T1, SRC_T2, SRC_T0, SRC_T1, SRC_T4,
        SRC_T4, SRC_T3, SRC_T5, SRC_T3, SRC_T5, SRC_T1, SRC_T0, SRC_T2, SRC_T4,
        SRC_T3, SRC_T5, SRC_T6, SRC_T7, SRC_T6, SRC_T7, SRC_D67, SRC_T9, SRC_T9
    };

    localparam t_coef LANE_COEF_TRAC [NUM_LANES] = '{
        K_C3, K_CS2, K_CS2, K_CS2, K_C3, K_C, K_C2S, K_C2S, K_C2S,
        K_S3, K_CS, K_CS, K_C2, K_S2, K_S3, K_S3, K_S, K_C3,
        K_S2, K_C2, K_C2, K_S2, K_S2, K_C2, K_CS, K_S, K_C
    };

    // Terms projected on nx, ny, nz for each result row
    localparam t_term ROW_TERM [NUM_LANES] = '{
        TM_XXX, TM_XXY, TM_XZX,
        TM_XXY, TM_XYY, TM_XYZ,
        TM_XZX, TM_XYZ, TM_XZZ,
        TM_YXX, TM_YXY, TM_XYZ,
        TM_YXY, TM_YYY, TM_YYZ,
        TM_XYZ, TM_YYZ, TM_YZZ,
        TM_ZXX, TM_ZXY, TM_ZZX,
        TM_ZXY, TM_ZYY, TM_ZYZ,
        TM_ZZX, TM_ZYZ, TM_ZZZ
    };

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] component_0;
        logic signed [31:0] component_1;
        logic signed [31:0] component_2;
        logic signed [31:0] component_3;
        logic signed [31:0] component_4;
        logic signed [31:0] component_5;
        logic signed [31:0] component_6;
        logic signed [31:0] component_7;
        logic signed [31:0] component_8;
        logic signed [31:0] component_9;
        logic               last_set;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_xx;
        logic signed [31:0] result_xy;
        logic signed [31:0] result_xz;
        logic signed [31:0] result_yx;
        logic signed [31:0] result_yy;
        logic signed [31:0] result_yz;
        logic signed [31:0] result_zx;
        logic signed [31:0] result_zy;
        logic signed [31:0] result_zz;
        logic               saturated;
        logic               last_out;
    } t_out;

endpackage

`default_nettype wire

### rtl/green_tensor_rotate_project.sv
// Green tensor rotate and project: eight-stage pipeline, one item per cycle.
// Accepted items pass stages 0 to 7 in order; stage 7 registers the result.
// One item per cycle unless busy; each accepted item gives exactly one result.
// Reset: synchronous, active low; busy is high in reset and the cycle after it.
// The receiver cannot stall; results are shown for one cycle on o_done.
// Depends on gtrp_pkg.
`default_nettype none

module green_tensor_rotate_project #(
    parameter int SAMPLE_BITS    = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire gtrp_pkg::t_in                     i_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [gtrp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gtrp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_done,
    output gtrp_pkg::t_out                         o_result
);

    localparam int SW = SAMPLE_BITS;
    localparam int IW = SAMPLE_BITS + 8;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = DW + 32;
    localparam int NW = IW + 32;
    localparam int XW = (NW > 64) ? NW : 64;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int NL = gtrp_pkg::NUM_LANES;
    localparam int NT = gtrp_pkg::NUM_TERMS;
    localparam int NR = gtrp_pkg::NUM_ROWS;
    localparam int NC = gtrp_pkg::NUM_COMP;

    // Round |p| / 2^F half away from zero, clip to a signed range of bits
    function automatic logic [XW:0] f_round(input logic signed [XW-1:0] p, input int bits);
        logic          neg;
        logic [XW-1:0] mag;
        logic [XW:0]   sum;
        logic [XW:0]   q;
        logic [XW:0]   lim;
        logic          clip;
        logic [XW-1:0] v;
        neg  = p[XW-1];
        mag  = neg ? -p : p;
        sum  = {1'b0, mag} + ({{XW{1'b0}}, 1'b1} << (F - 1));
        q    = sum >> F;
        lim  = {{XW{1'b0}}, 1'b1} << (bits - 1);
        if (!neg) begin
            lim = lim - 1'b1;
        end
        clip = (q > lim);
        if (clip) begin
            q = lim;
        end
        v = neg ? -q[XW-1:0] : q[XW-1:0];
        return {clip, v};
    endfunction

    // Clip a signed value to a signed range of bits
    function automatic logic [XW:0] f_sat(input logic signed [XW-1:0] v, input int bits);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = ({{(XW-1){1'b0}}, 1'b1} <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return {1'b1, hi};
        end
        if (v < lo) begin
            return {1'b1, lo};
        end
        return {1'b0, v};
    endfunction

    function automatic logic [32:0] f_round_k(input logic signed [63:0] p);
        logic [XW:0] r;
        r = f_round(XW'(p), 32);
        return {r[XW], r[31:0]};
    endfunction

    function automatic logic [IW:0] f_round_iw(input logic signed [XW-1:0] p);
        logic [XW:0] r;
        r = f_round(p, IW);
        return {r[XW], r[IW-1:0]};
    endfunction

    function automatic logic [IW:0] f_sat_iw(input logic signed [XW-1:0] v);
        logic [XW:0] r;
        r = f_sat(v, IW);
        return {r[XW], r[IW-1:0]};
    endfunction

    function automatic logic [SW:0] f_sat_sw(input logic signed [XW-1:0] v);
        logic [XW:0] r;
        r = f_sat(v, SW);
        return {r[XW], r[SW-1:0]};
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [31:0] r_cos, r_sin, r_nx, r_ny, r_nz;
    logic               r_busy;

    // Write a register; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= gtrp_pkg::COS_RESET;
            r_sin <= '0;
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtrp_pkg::CFG_COS: r_cos <= i_cfg_data;
                gtrp_pkg::CFG_SIN: r_sin <= i_cfg_data;
                gtrp_pkg::CFG_NX:  r_nx  <= i_cfg_data;
                gtrp_pkg::CFG_NY:  r_ny  <= i_cfg_data;
                gtrp_pkg::CFG_NZ:  r_nz  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold busy through reset and the cycle after it, so trig terms settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // ---------------------------------------------------------------
    // Trig coefficients, refreshed every cycle from the registers
    // ---------------------------------------------------------------
    logic signed [31:0] r_c2, r_s2, r_cs, r_c3, r_s3, r_cs2, r_c2s;
    logic               r_kf1, r_kf2;
    logic [32:0]        n_c2, n_s2, n_cs, n_c3, n_s3, n_cs2, n_c2s;

    always_comb begin
        n_c2  = f_round_k(r_cos * r_cos);
        n_s2  = f_round_k(r_sin * r_sin);
        n_cs  = f_round_k(r_cos * r_sin);
        n_c3  = f_round_k(r_c2 * r_cos);
        n_s3  = f_round_k(r_s2 * r_sin);
        n_cs2 = f_round_k(r_cos * r_s2);
        n_c2s = f_round_k(r_c2 * r_sin);
    end

    always_ff @(posedge i_clk) begin
        r_c2  <= n_c2[31:0];
        r_s2  <= n_s2[31:0];
        r_cs  <= n_cs[31:0];
        r_kf1 <= n_c2[32] | n_s2[32] | n_cs[32];
        r_c3  <= n_c3[31:0];
        r_s3  <= n_s3[31:0];
        r_cs2 <= n_cs2[31:0];
        r_c2s <= n_c2s[31:0];
        r_kf2 <= r_kf1 | n_c3[32] | n_s3[32] | n_cs2[32] | n_c2s[32];
    end

    // ---------------------------------------------------------------
    // Stage 0: capture the item
    // ---------------------------------------------------------------
    logic [31:0]          w_comp [NC];
    logic signed [SW-1:0] w_t    [NC];

    assign w_comp[0] = i_item.component_0;
    assign w_comp[1] = i_item.component_1;
    assign w_comp[2] = i_item.component_2;
    assign w_comp[3] = i_item.component_3;
    assign w_comp[4] = i_item.component_4;
    assign w_comp[5] = i_item.component_5;
    assign w_comp[6] = i_item.component_6;
    assign w_comp[7] = i_item.component_7;
    assign w_comp[8] = i_item.component_8;
    assign w_comp[9] = i_item.component_9;

    // Take samples at SAMPLE_BITS, sign-extending from the port if wider
    for (genvar g = 0; g < NC; g++) begin : g_in
        if (SW <= 32) begin : g_narrow
            assign w_t[g] = w_comp[g][SW-1:0];
        end else begin : g_wide
            assign w_t[g] = {{(SW-32){w_comp[g][31]}}, w_comp[g]};
        end
    end

    logic                 r_v0;
    gtrp_pkg::t_op        r_op0;
    logic                 r_last0;
    logic signed [SW-1:0] r_t0 [NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start & ~r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op0   <= i_item.operation;
        r_last0 <= i_item.last_set;
        for (int k = 0; k < NC; k++) begin
            r_t0[k] <= w_t[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: pick the sample operand of each lane
    // ---------------------------------------------------------------
    logic signed [DW-1:0] w_src [13];

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            w_src[k] = DW'(r_t0[k]);
        end
        w_src[gtrp_pkg::SRC_D02]  = DW'(r_t0[0]) - DW'(r_t0[2]);
        w_src[gtrp_pkg::SRC_D67]  = DW'(r_t0[6]) - DW'(r_t0[7]);
        w_src[gtrp_pkg::SRC_ZERO] = '0;
    end

    logic                 r_v1;
    gtrp_pkg::t_op        r_op1;
    logic                 r_last1;
    logic signed [SW-1:0] r_pass1;
    logic signed [DW-1:0] r_x1 [NL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1   <= r_op0;
        r_last1 <= r_last0;
        r_pass1 <= (r_op0 == gtrp_pkg::OP_TRAC) ? r_t0[8] : r_t0[4];
        for (int k = 0; k < NL; k++) begin
            if (r_op0 == gtrp_pkg::OP_TRAC) begin
                r_x1[k] <= w_src[gtrp_pkg::LANE_SRC_TRAC[k]];
            end else begin
                r_x1[k] <= w_src[gtrp_pkg::LANE_SRC_DISP[k]];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: coefficient times sample, one multiplier per lane
    // ---------------------------------------------------------------
    logic signed [31:0] w_kv [9];

    always_comb begin
        w_kv[gtrp_pkg::K_C]   = r_cos;
        w_kv[gtrp_pkg::K_S]   = r_sin;
        w_kv[gtrp_pkg::K_C2]  = r_c2;
        w_kv[gtrp_pkg::K_S2]  = r_s2;
        w_kv[gtrp_pkg::K_CS]  = r_cs;
        w_kv[gtrp_pkg::K_C3]  = r_c3;
        w_kv[gtrp_pkg::K_S3]  = r_s3;
        w_kv[gtrp_pkg::K_CS2] = r_cs2;
        w_kv[gtrp_pkg::K_C2S] = r_c2s;
    end

    logic                 r_v2;
    gtrp_pkg::t_op        r_op2;
    logic                 r_last2;
    logic                 r_f2;
    logic signed [SW-1:0] r_pass2;
    logic signed [PW-1:0] r_p2 [NL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op2   <= r_op1;
        r_last2 <= r_last1;
        r_f2    <= r_kf2;
        r_pass2 <= r_pass1;
        for (int k = 0; k < NL; k++) begin
            if (r_op1 == gtrp_pkg::OP_TRAC) begin
                r_p2[k] <= w_kv[gtrp_pkg::LANE_COEF_TRAC[k]] * r_x1[k];
            end else begin
                r_p2[k] <= w_kv[gtrp_pkg::LANE_COEF_DISP[k]] * r_x1[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: round and clip each lane product
    // ---------------------------------------------------------------
    logic [IW:0] w_m2 [NL];
    logic        w_f2;

    always_comb begin
        w_f2 = 1'b0;
        for (int k = 0; k < NL; k++) begin
            w_m2[k] = f_round_iw(XW'(r_p2[k]));
            w_f2    = w_f2 | w_m2[k][IW];
        end
    end

    logic                 r_v3;
    gtrp_pkg::t_op        r_op3;
    logic                 r_last3;
    logic                 r_f3;
    logic signed [SW-1:0] r_pass3;
    logic signed [IW-1:0] r_m3 [NL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op3   <= r_op2;
        r_last3 <= r_last2;
        r_f3    <= r_f2 | w_f2;
        r_pass3 <= r_pass2;
        for (int k = 0; k < NL; k++) begin
            r_m3[k] <= w_m2[k][IW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: traction terms, or displacement results
    // ---------------------------------------------------------------
    logic signed [XW-1:0] w_m   [NL];
    logic signed [XW-1:0] w_ts  [NT];
    logic signed [XW-1:0] w_ds  [NR];
    logic [IW:0]          w_tc  [NT];
    logic [SW:0]          w_dc  [NR];
    logic signed [XW-1:0] w_pass;
    logic                 w_tf, w_df;

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_m[k] = XW'(r_m3[k]);
        end
        w_pass = XW'(r_pass3);

        w_ts[gtrp_pkg::TM_XXX] = w_m[0] + w_m[1] + (w_m[2] <<< 1);
        w_ts[gtrp_pkg::TM_XYY] = w_m[3] + w_m[4] - (w_m[2] <<< 1);
        w_ts[gtrp_pkg::TM_XZZ] = w_m[5];
        w_ts[gtrp_pkg::TM_XXY] = w_m[6] - w_m[7] - w_m[8] + w_m[9];
        w_ts[gtrp_pkg::TM_XYZ] = w_m[10] - w_m[11];
        w_ts[gtrp_pkg::TM_XZX] = w_m[12] + w_m[13];
        w_ts[gtrp_pkg::TM_YXX] = w_m[6] - (w_m[8] <<< 1) + w_m[14];
        w_ts[gtrp_pkg::TM_YYY] = w_m[15] + (w_m[8] <<< 1) + w_m[7];
        w_ts[gtrp_pkg::TM_YZZ] = w_m[16];
        w_ts[gtrp_pkg::TM_YXY] = w_m[3] - w_m[2] + w_m[17] - w_m[1];
        w_ts[gtrp_pkg::TM_YYZ] = w_m[18] + w_m[19];
        w_ts[gtrp_pkg::TM_ZXX] = w_m[20] + w_m[21];
        w_ts[gtrp_pkg::TM_ZYY] = w_m[22] + w_m[23];
        w_ts[gtrp_pkg::TM_ZZZ] = w_pass;
        w_ts[gtrp_pkg::TM_ZXY] = w_m[24];
        w_ts[gtrp_pkg::TM_ZYZ] = w_m[25];
        w_ts[gtrp_pkg::TM_ZZX] = w_m[26];

        w_ds[0] = w_m[0] + w_m[1];
        w_ds[1] = w_m[2];
        w_ds[2] = w_m[3];
        w_ds[3] = w_m[2];
        w_ds[4] = w_m[4] + w_m[5];
        w_ds[5] = w_m[6];
        w_ds[6] = w_m[7];
        w_ds[7] = w_m[8];
        w_ds[8] = w_pass;

        // Clip terms; values already in range pass without a flag
        w_tf = 1'b0;
        for (int k = 0; k < NT; k++) begin
            w_tc[k] = f_sat_iw(w_ts[k]);
            w_tf    = w_tf | w_tc[k][IW];
        end
        w_df = 1'b0;
        for (int k = 0; k < NR; k++) begin
            w_dc[k] = f_sat_sw(w_ds[k]);
            w_df    = w_df | w_dc[k][SW];
        end
    end

    logic                 r_v4;
    gtrp_pkg::t_op        r_op4;
    logic                 r_last4;
    logic                 r_f4;
    logic signed [IW-1:0] r_e4 [NT];
    logic signed [SW-1:0] r_d4 [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op4   <= r_op3;
        r_last4 <= r_last3;
        r_f4    <= r_f3 | ((r_op3 == gtrp_pkg::OP_TRAC) ? w_tf : w_df);
        for (int k = 0; k < NT; k++) begin
            r_e4[k] <= w_tc[k][IW-1:0];
        end
        for (int k = 0; k < NR; k++) begin
            r_d4[k] <= w_dc[k][SW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: project terms on the element normal
    // ---------------------------------------------------------------
    logic signed [31:0] w_nrm [3];

    assign w_nrm[0] = r_nx;
    assign w_nrm[1] = r_ny;
    assign w_nrm[2] = r_nz;

    logic                 r_v5;
    gtrp_pkg::t_op        r_op5;
    logic                 r_last5;
    logic                 r_f5;
    logic signed [NW-1:0] r_np5 [NL];
    logic signed [SW-1:0] r_d5  [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op5   <= r_op4;
        r_last5 <= r_last4;
        r_f5    <= r_f4;
        for (int r = 0; r < NR; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_np5[r*3+c] <= r_e4[gtrp_pkg::ROW_TERM[r*3+c]] * w_nrm[c];
            end
            r_d5[r] <= r_d4[r];
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: round and clip the projections
    // ---------------------------------------------------------------
    logic [IW:0] w_q5 [NL];
    logic        w_f5;

    always_comb begin
        w_f5 = 1'b0;
        for (int k = 0; k < NL; k++) begin
            w_q5[k] = f_round_iw(XW'(r_np5[k]));
            w_f5    = w_f5 | w_q5[k][IW];
        end
    end

    logic                 r_v6;
    gtrp_pkg::t_op        r_op6;
    logic                 r_last6;
    logic                 r_f6;
    logic signed [IW-1:0] r_q6 [NL];
    logic signed [SW-1:0] r_d6 [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op6   <= r_op5;
        r_last6 <= r_last5;
        r_f6    <= r_f5 | ((r_op5 == gtrp_pkg::OP_TRAC) & w_f5);
        for (int k = 0; k < NL; k++) begin
            r_q6[k] <= w_q5[k][IW-1:0];
        end
        for (int k = 0; k < NR; k++) begin
            r_d6[k] <= r_d5[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: sum each row, clip, register the result
    // ---------------------------------------------------------------
    logic signed [XW-1:0] w_rs  [NR];
    logic [SW:0]          w_rc  [NR];
    logic signed [SW-1:0] w_res [NR];
    logic [31:0]          w_port [NR];
    logic                 w_rf;

    always_comb begin
        w_rf = 1'b0;
        for (int r = 0; r < NR; r++) begin
            w_rs[r] = XW'(r_q6[r*3]) + XW'(r_q6[r*3+1]) + XW'(r_q6[r*3+2]);
            w_rc[r] = f_sat_sw(w_rs[r]);
            w_rf    = w_rf | w_rc[r][SW];
            w_res[r] = (r_op6 == gtrp_pkg::OP_TRAC) ? w_rc[r][SW-1:0] : r_d6[r];
        end
    end

    // Fit SAMPLE_BITS results to the 32-bit fields
    for (genvar g = 0; g < NR; g++) begin : g_out
        if (SW < 32) begin : g_narrow
            assign w_port[g] = {{(32-SW){1'b0}}, w_res[g]};
        end else if (SW == 32) begin : g_same
            assign w_port[g] = w_res[g];
        end else begin : g_wide
            assign w_port[g] = w_res[g][31:0];
        end
    end

    gtrp_pkg::t_out r_out;
    logic           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.result_xx <= w_port[0];
        r_out.result_xy <= w_port[1];
        r_out.result_xz <= w_port[2];
        r_out.result_yx <= w_port[3];
        r_out.result_yy <= w_port[4];
        r_out.result_yz <= w_port[5];
        r_out.result_zx <= w_port[6];
        r_out.result_zy <= w_port[7];
        r_out.result_zz <= w_port[8];
        r_out.saturated <= r_f6 | ((r_op6 == gtrp_pkg::OP_TRAC) & w_rf);
        r_out.last_out  <= r_last6;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

`default_nettype wire
